// ===== src/catmull_rom_3d_interpolator_defines.svh =====
// ----------------------------------------------------------------------------
// Catmull-Rom 3D interpolator assertion macros
// Shared property macros for the checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_3D_INTERPOLATOR_DEFINES_SVH
`define CATMULL_ROM_3D_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CR3D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CR3D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cr3d_pkg.sv =====
// ----------------------------------------------------------------------------
// Catmull-Rom 3D interpolator package
// Widths, item types, sequencer codes and the spline coefficient function.
// ----------------------------------------------------------------------------
package cr3d_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TIME_BITS  = 32;

   // Working width of the Horner accumulator; the worst case needs COORD_BITS + 5.
   localparam int H_BITS   = COORD_BITS + 6;
   localparam int T_BITS   = FRAC_BITS + 1;
   localparam int LO_BITS  = H_BITS / 2;
   localparam int HI_BITS  = H_BITS - LO_BITS;
   localparam int P_BITS   = H_BITS + T_BITS + 1;
   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

   localparam logic [TIME_BITS-1:0] INTERVAL_RESET = TIME_BITS'(65536);

   typedef struct packed {
      logic                         mode;
      logic signed [COORD_BITS-1:0] in_x;
      logic signed [COORD_BITS-1:0] in_y;
      logic signed [COORD_BITS-1:0] in_z;
      logic [TIME_BITS-1:0]         elapsed;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
      logic                         time_was_late;
   } rsp_item_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_EVAL = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_ACC,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      COEF_A3,
      COEF_A2,
      COEF_A1,
      COEF_P1X2
   } coef_sel_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic load;
      logic mul_hi;
      logic mul_lo;
      logic acc;
   } mac_ctrl_type;

   function automatic logic signed [H_BITS-1:0] coef_term(
      input logic signed [COORD_BITS-1:0] p0,
      input logic signed [COORD_BITS-1:0] p1,
      input logic signed [COORD_BITS-1:0] p2,
      input logic signed [COORD_BITS-1:0] p3,
      input coef_sel_type                 sel
   );
      logic signed [H_BITS-1:0] e0;
      logic signed [H_BITS-1:0] e1;
      logic signed [H_BITS-1:0] e2;
      logic signed [H_BITS-1:0] e3;
      logic signed [H_BITS-1:0] d;
      logic signed [H_BITS-1:0] r;
      e0 = H_BITS'(p0);
      e1 = H_BITS'(p1);
      e2 = H_BITS'(p2);
      e3 = H_BITS'(p3);
      d  = e1 - e2;
      unique case (sel)
         COEF_A3:   r = e3 - e0 + (d <<< 1) + d;
         COEF_A2:   r = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
         COEF_A1:   r = e2 - e0;
         COEF_P1X2: r = e1 <<< 1;
         default:   r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] coord_of(
      input point_type p,
      input axis_type  a
   );
      logic signed [COORD_BITS-1:0] r;
      unique case (a)
         AXIS_X:  r = p.x;
         AXIS_Y:  r = p.y;
         AXIS_Z:  r = p.z;
         default: r = p.x;
      endcase
      return r;
   endfunction

endpackage

// ===== src/cr3d_divider.sv =====
// ----------------------------------------------------------------------------
// Segment fraction divider
// Restoring divider that forms t = dividend * 2^FRAC_BITS / divisor, one bit
// per cycle, for a dividend that never exceeds the divisor.
// ----------------------------------------------------------------------------
module cr3d_divider
   import cr3d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] dividend,
   input  logic [TIME_BITS-1:0] divisor,
   output logic                 busy,
   output logic [T_BITS-1:0]    quotient
);

   logic                 busy_ff,    busy_in;
   logic [CNT_BITS-1:0]  count_ff,   count_in;
   logic [TIME_BITS-1:0] rem_ff,     rem_in;
   logic [TIME_BITS-1:0] divisor_ff, divisor_in;
   logic [T_BITS-1:0]    quot_ff,    quot_in;
   logic [TIME_BITS:0]   rem_dbl;
   logic [TIME_BITS:0]   rem_diff;
   logic                 fits;

   assign rem_dbl  = {rem_ff, 1'b0};
   assign rem_diff = rem_dbl - {1'b0, divisor_ff};
   assign fits     = rem_dbl >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (start) begin
         divisor_in = divisor;
         count_in   = CNT_BITS'(FRAC_BITS);
         // A zero divisor yields t = 0 without running the loop.
         busy_in    = (divisor != '0);
         if (divisor == '0) begin
            quot_in = '0;
            rem_in  = '0;
         end else if (dividend == divisor) begin
            quot_in = T_BITS'(1);
            rem_in  = '0;
         end else begin
            quot_in = '0;
            rem_in  = dividend;
         end
      end else if (busy_ff) begin
         quot_in  = {quot_ff[T_BITS-2:0], fits};
         rem_in   = fits ? rem_diff[TIME_BITS-1:0] : rem_dbl[TIME_BITS-1:0];
         count_in = count_ff - CNT_BITS'(1);
         busy_in  = (count_ff != CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ===== src/cr3d_horner_unit.sv =====
// ----------------------------------------------------------------------------
// Shared Horner multiply-accumulate unit
// Evaluates h = addend + floor(h * t / 2^FRAC_BITS) with one split multiplier
// used on the high half and then the low half, and rounds and saturates the final sum.
// ----------------------------------------------------------------------------
module cr3d_horner_unit
   import cr3d_pkg::*;
(
   input  logic                         clock,
   input  mac_ctrl_type                 ctrl,
   input  logic signed [H_BITS-1:0]     addend,
   input  logic [T_BITS-1:0]            t_frac,
   output logic signed [COORD_BITS-1:0] result
);

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam int MUL_BITS = HI_BITS + T_BITS + 2;

   logic signed [H_BITS-1:0]       h_ff,      h_in;
   logic signed [H_BITS-1:0]       addend_ff, addend_in;
   logic signed [P_BITS-1:0]       prod_ff,   prod_in;
   logic signed [HI_BITS-1:0]      h_hi;
   logic [LO_BITS-1:0]             h_lo;
   logic signed [T_BITS:0]         t_signed;
   logic signed [HI_BITS:0]        mul_a;
   logic signed [MUL_BITS-1:0]     mul_prod;
   logic signed [P_BITS-1:0]       mul_ext;
   logic signed [P_BITS-1:0]       prod_shr;
   logic [H_BITS:0]                h_plus;
   logic [H_BITS-1:0]              rounded;
   logic [H_BITS-COORD_BITS:0]     top_bits;

   assign h_hi     = h_ff[H_BITS-1:LO_BITS];
   assign h_lo     = h_ff[LO_BITS-1:0];
   assign t_signed = {1'b0, t_frac};
   // The low half is unsigned, so it enters the multiplier zero-extended.
   assign mul_a    = ctrl.mul_lo ? $signed({{(HI_BITS+1-LO_BITS){1'b0}}, h_lo})
                                 : $signed({h_hi[HI_BITS-1], h_hi});
   assign mul_prod = mul_a * t_signed;
   assign mul_ext  = {{(P_BITS-MUL_BITS){mul_prod[MUL_BITS-1]}}, mul_prod};
   assign prod_shr = prod_ff >>> FRAC_BITS;

   always_comb begin
      h_in      = h_ff;
      addend_in = addend_ff;
      prod_in   = prod_ff;
      if (ctrl.load) begin
         h_in = addend;
      end
      if (ctrl.mul_hi) begin
         prod_in   = mul_ext;
         addend_in = addend;
      end
      // The low half product joins the shifted high half.
      if (ctrl.mul_lo) begin
         prod_in = (prod_ff <<< LO_BITS) + mul_ext;
      end
      if (ctrl.acc) begin
         h_in = addend_ff + prod_shr[H_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      h_ff      <= h_in;
      addend_ff <= addend_in;
      prod_ff   <= prod_in;
   end

   // The sum is twice the point, so halve it with round half up.
   assign h_plus   = {h_ff[H_BITS-1], h_ff} + (H_BITS+1)'(1);
   assign rounded  = h_plus[H_BITS:1];
   assign top_bits = rounded[H_BITS-1:COORD_BITS-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         result = rounded[COORD_BITS-1:0];
      end else if (rounded[H_BITS-1]) begin
         result = COORD_MIN;
      end else begin
         result = COORD_MAX;
      end
   end

endmodule

// ===== src/catmull_rom_3d_interpolator.sv =====
// A push item is absorbed without leaving the idle state; an evaluate item on an empty history
// has its result valid in the cycle after acceptance, otherwise the fraction t is first formed in
// the serial divider, which skips its loop when segment_interval is zero, and then each axis
// in turn is evaluated in the shared Horner multiplier.
// One item is in flight at a time; the next is accepted in the cycle after the result is taken.
// Synchronous reset clears the point history to zero and loads segment_interval 65536.
`include "catmull_rom_3d_interpolator_defines.svh"
// ----------------------------------------------------------------------------
// Catmull-Rom 3D interpolator
// Keeps a four-point history and returns the uniform Catmull-Rom point between the
// middle two entries, one axis after another, or the newest entry if the oldest is zero.
// ----------------------------------------------------------------------------
module catmull_rom_3d_interpolator
   import cr3d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_item,
   input  logic                 csr_write_enable,
   input  logic [TIME_BITS-1:0] csr_write_data
);

   state_type            state_ff,    state_in;
   coef_sel_type         step_ff,     step_in;
   axis_type             axis_ff,     axis_in;
   logic [TIME_BITS-1:0] interval_ff, interval_in;
   point_type            hist_ff [4];
   point_type            hist_in [4];
   rsp_item_type         rsp_ff,      rsp_in;

   logic                         req_accept;
   logic                         push_accept;
   logic                         hist_empty;
   logic                         late;
   logic [TIME_BITS-1:0]         eff_elapsed;
   logic                         div_start;
   logic                         div_busy;
   logic [T_BITS-1:0]            t_frac;
   mac_ctrl_type                 mac_ctrl;
   coef_sel_type                 coef_sel;
   logic signed [H_BITS-1:0]     addend;
   logic signed [COORD_BITS-1:0] axis_result;

   assign req_accept  = req_valid && !req_stall;
   assign push_accept = req_accept && (req_item.mode == MODE_PUSH);
   assign hist_empty  = (hist_ff[0] == '0);
   assign late        = (req_item.elapsed > interval_ff);
   assign eff_elapsed = late ? '0 : req_item.elapsed;
   assign coef_sel    = (state_ff == ST_LOAD) ? COEF_A3 : step_ff;
   assign addend      = coef_term(
                           coord_of(hist_ff[0], axis_ff), coord_of(hist_ff[1], axis_ff),
                           coord_of(hist_ff[2], axis_ff), coord_of(hist_ff[3], axis_ff),
                           coef_sel);

   cr3d_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (eff_elapsed),
      .divisor  (interval_ff),
      .busy     (div_busy),
      .quotient (t_frac)
   );

   cr3d_horner_unit u_horner (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .addend (addend),
      .t_frac (t_frac),
      .result (axis_result)
   );

   always_comb begin
      interval_in = csr_write_enable ? csr_write_data : interval_ff;
   end

   always_comb begin
      hist_in = hist_ff;
      if (push_accept) begin
         hist_in[0]   = hist_ff[1];
         hist_in[1]   = hist_ff[2];
         hist_in[2]   = hist_ff[3];
         hist_in[3].x = req_item.in_x;
         hist_in[3].y = req_item.in_y;
         hist_in[3].z = req_item.in_z;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      axis_in   = axis_ff;
      rsp_in    = rsp_ff;
      mac_ctrl  = '0;
      div_start = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESPOND);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_item.mode == MODE_EVAL)) begin
               if (hist_empty) begin
                  rsp_in.out_x         = hist_ff[3].x;
                  rsp_in.out_y         = hist_ff[3].y;
                  rsp_in.out_z         = hist_ff[3].z;
                  rsp_in.time_was_late = 1'b0;
                  state_in             = ST_RESPOND;
               end else begin
                  rsp_in.time_was_late = late;
                  div_start            = 1'b1;
                  state_in             = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               axis_in  = AXIS_X;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mac_ctrl.load = 1'b1;
            step_in       = COEF_A2;
            state_in      = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mac_ctrl.mul_hi = 1'b1;
            state_in        = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mac_ctrl.mul_lo = 1'b1;
            state_in        = ST_ACC;
         end
         ST_ACC: begin
            mac_ctrl.acc = 1'b1;
            unique case (step_ff)
               COEF_A2: begin
                  step_in  = COEF_A1;
                  state_in = ST_MUL_HI;
               end
               COEF_A1: begin
                  step_in  = COEF_P1X2;
                  state_in = ST_MUL_HI;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_FINISH: begin
            unique case (axis_ff)
               AXIS_X: begin
                  rsp_in.out_x = axis_result;
                  axis_in      = AXIS_Y;
                  state_in     = ST_LOAD;
               end
               AXIS_Y: begin
                  rsp_in.out_y = axis_result;
                  axis_in      = AXIS_Z;
                  state_in     = ST_LOAD;
               end
               default: begin
                  rsp_in.out_z = axis_result;
                  state_in     = ST_RESPOND;
               end
            endcase
         end
         ST_RESPOND: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= COEF_A3;
         axis_ff     <= AXIS_X;
         interval_ff <= INTERVAL_RESET;
         for (int i = 0; i < 4; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         axis_ff     <= axis_in;
         interval_ff <= interval_in;
         hist_ff     <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_item = rsp_ff;

   `CR3D_ASSERT_SAME(a_single_item, clock, reset, rsp_valid, req_stall, "input open with result")
   `CR3D_ASSERT_NEXT(a_push_silent, clock, reset, push_accept, !rsp_valid, "push gave a result")
   `CR3D_ASSERT_SAME(a_div_phase, clock, reset, div_busy, state_ff == ST_DIV, "divider misaligned")

endmodule

// ===== tb/tb_catmull_rom_3d_interpolator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Catmull-Rom 3D interpolator testbench
// Sends push and evaluate items through the request channel with random gaps
// and response stalls. A built-in Horner predictor computes every expected
// point, and each response is compared field by field.
// ----------------------------------------------------------------------------
module tb_catmull_rom_3d_interpolator;
   import cr3d_pkg::*;

   localparam int     EVAL_CYCLES  = FRAC_BITS + 35;
   localparam int     HOLD_CYCLES  = 300;
   localparam longint COORD_MAX    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN    = -COORD_MAX - 1;
   localparam logic [COORD_BITS-1:0] MAX_C = COORD_MAX[COORD_BITS-1:0];
   localparam logic [COORD_BITS-1:0] MIN_C = COORD_MIN[COORD_BITS-1:0];
   localparam logic [TIME_BITS-1:0]  TIME_MAX = '1;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_item_type         req_item;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_item_type         rsp_item;
   logic                 csr_write_enable;
   logic [TIME_BITS-1:0] csr_write_data;

   // Predictor state: the point history and the segment interval.
   point_type            history [4];
   logic [TIME_BITS-1:0] interval_setting;
   rsp_item_type         expected_points [$];

   bit idle_enable;
   bit hold_request;
   int items_sent;
   int evals_sent;
   int late_expected;
   int results_seen;
   int error_count;
   int settings_used;

   catmull_rom_3d_interpolator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_catmull_rom_3d_interpolator NOT OK");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (!idle_enable || r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Twice-scaled Horner evaluation of one axis with round-half-up at the end.
   function automatic logic [COORD_BITS-1:0] catmull_rom_axis(
      input logic signed [COORD_BITS-1:0] c0,
      input logic signed [COORD_BITS-1:0] c1,
      input logic signed [COORD_BITS-1:0] c2,
      input logic signed [COORD_BITS-1:0] c3,
      input longint                       t
   );
      longint p0;
      longint p1;
      longint p2;
      longint p3;
      longint h;
      longint r;
      p0 = c0;
      p1 = c1;
      p2 = c2;
      p3 = c3;
      h = -p0 + 3 * p1 - 3 * p2 + p3;
      h = (2 * p0 - 5 * p1 + 4 * p2 - p3) + ((h * t) >>> FRAC_BITS);
      h = (p2 - p0) + ((h * t) >>> FRAC_BITS);
      h = 2 * p1 + ((h * t) >>> FRAC_BITS);
      r = (h + 1) >>> 1;
      if (r > COORD_MAX) r = COORD_MAX;
      if (r < COORD_MIN) r = COORD_MIN;
      return r[COORD_BITS-1:0];
   endfunction

   task automatic predict_interpolation(input req_item_type it);
      rsp_item_type         e;
      logic [63:0]          scaled;
      logic [TIME_BITS-1:0] elapsed;
      longint               t;
      if (it.mode == MODE_PUSH) begin
         for (int i = 0; i < 3; i++) history[i] = history[i + 1];
         history[3] = '{x: it.in_x, y: it.in_y, z: it.in_z};
         return;
      end
      evals_sent++;
      if (history[0] == '0) begin
         // Nothing old enough to interpolate from: the newest point comes back.
         e.out_x = history[3].x;
         e.out_y = history[3].y;
         e.out_z = history[3].z;
         e.time_was_late = 1'b0;
      end else begin
         elapsed = it.elapsed;
         e.time_was_late = 1'b0;
         if (elapsed > interval_setting) begin
            elapsed = '0;
            e.time_was_late = 1'b1;
            late_expected++;
         end
         scaled = {32'b0, elapsed} << FRAC_BITS;
         t = (interval_setting != 0) ? longint'(scaled / {32'b0, interval_setting}) : 0;
         e.out_x = catmull_rom_axis($signed(history[0].x), $signed(history[1].x),
                                    $signed(history[2].x), $signed(history[3].x), t);
         e.out_y = catmull_rom_axis($signed(history[0].y), $signed(history[1].y),
                                    $signed(history[2].y), $signed(history[3].y), t);
         e.out_z = catmull_rom_axis($signed(history[0].z), $signed(history[1].z),
                                    $signed(history[2].z), $signed(history[3].z), t);
      end
      expected_points.push_back(e);
   endtask

   // Must be called just after a rising edge.
   task automatic send_item(input req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_interpolation(it);
      items_sent++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (EVAL_CYCLES + 8) @(posedge clock);
   endtask

   task automatic write_interval(input logic [TIME_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      interval_setting = value;
      settings_used++;
   endtask

   function automatic req_item_type make_push(input point_type p);
      req_item_type it;
      it.mode    = MODE_PUSH;
      it.in_x    = p.x;
      it.in_y    = p.y;
      it.in_z    = p.z;
      it.elapsed = $urandom;
      return it;
   endfunction

   function automatic req_item_type make_eval(input logic [TIME_BITS-1:0] elapsed);
      req_item_type it;
      it.mode    = MODE_EVAL;
      it.in_x    = $urandom;
      it.in_y    = $urandom;
      it.in_z    = $urandom;
      it.elapsed = elapsed;
      return it;
   endfunction

   function automatic point_type make_point(input logic [COORD_BITS-1:0] x,
                                            input logic [COORD_BITS-1:0] y,
                                            input logic [COORD_BITS-1:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coord();
      int r;
      r = $urandom_range(15, 0);
      if (r == 0) return MIN_C;
      if (r == 1) return MAX_C;
      if (r == 2) return '0;
      if (r < 7) return $urandom_range(32'h0020_0000, 0) - 32'h0010_0000;
      return $urandom;
   endfunction

   function automatic point_type pick_point();
      if ($urandom_range(11, 0) == 0) return '0;
      return make_point(pick_coord(), pick_coord(), pick_coord());
   endfunction

   function automatic logic [TIME_BITS-1:0] pick_elapsed();
      int r;
      r = $urandom_range(9, 0);
      if (r == 0) return interval_setting;
      if (r == 1) return '0;
      if (r == 2 && interval_setting != TIME_MAX)
         return $urandom_range(TIME_MAX, interval_setting + 1);
      if (r < 4) return $urandom;
      return $urandom_range(interval_setting, 0);
   endfunction

   task automatic check_field(input string name, input logic [COORD_BITS-1:0] exp_v,
                              input logic [COORD_BITS-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Response checker.
   initial begin
      rsp_item_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h",
                        $realtime, rsp_item);
               error_count++;
            end else begin
               e = expected_points.pop_front();
               check_field("out_x", e.out_x, rsp_item.out_x);
               check_field("out_y", e.out_y, rsp_item.out_y);
               check_field("out_z", e.out_z, rsp_item.out_z);
               check_field("time_was_late", 32'(e.time_was_late),
                           32'(rsp_item.time_was_late));
            end
         end
      end
   end

   // Response stall driver; a requested hold keeps stall high for a counted stretch.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Evaluation on an empty or partly empty history, including an entry that is
   // zero on two axes only.
   task automatic test_empty_history();
      send_item(make_eval('0));
      send_item(make_eval(TIME_MAX));
      send_item(make_push(make_point(32'h1234_5678, 32'hFFFF_FFFF, MIN_C)));
      send_item(make_eval(32'h0000_8000));
      send_item(make_push(make_point('0, '0, 32'd5)));
      send_item(make_push(make_point(MAX_C, 32'h8000_0001, 32'h0001_0000)));
      send_item(make_eval(TIME_MAX));
      send_item(make_push(make_point(32'hFFFE_0000, 32'h7FFF_0000, '0)));
      send_item(make_push(make_point(32'h0003_8000, '0, 32'hFFFF_FFFF)));
      send_item(make_eval(32'h0000_4000));
   endtask

   // Full-scale points that overshoot, at both ends of the segment and past it.
   task automatic test_segment_extremes();
      send_item(make_push(make_point(MIN_C, MIN_C, 32'd1)));
      send_item(make_push(make_point(MAX_C, 32'h0001_0000, '0)));
      send_item(make_push(make_point(MAX_C, 32'hFFFF_0000, 32'hFFFF_FFFF)));
      send_item(make_push(make_point(MIN_C, MAX_C, 32'd2)));
      send_item(make_eval('0));
      send_item(make_eval(interval_setting));
      send_item(make_eval(interval_setting >> 1));
      send_item(make_eval(32'd1));
      send_item(make_eval(interval_setting - 1));
      send_item(make_eval(interval_setting + 1));
      send_item(make_eval(TIME_MAX));
   endtask

   task automatic test_interval_extremes();
      wait_results_drained();
      write_interval(32'd1);
      send_item(make_eval('0));
      send_item(make_eval(32'd1));
      send_item(make_eval(32'd2));
      wait_results_drained();
      write_interval(TIME_MAX);
      send_item(make_eval(TIME_MAX));
      send_item(make_eval(32'h7FFF_FFFF));
      wait_results_drained();
      write_interval(INTERVAL_RESET);
   endtask

   // The receiver holds off while the sender keeps offering items.
   task automatic test_long_hold();
      wait_results_drained();
      hold_request = 1'b1;
      repeat (4) send_item(make_push(pick_point()));
      repeat (3) send_item(make_eval(pick_elapsed()));
      send_item(make_push(pick_point()));
      send_item(make_eval(pick_elapsed()));
      wait_results_drained();
   endtask

   task automatic run_random_burst();
      int sel;
      int n_push;
      int n_eval;
      logic [5*32-1:0] raw;
      req_item_type it;
      sel = $urandom_range(9, 0);
      if (sel == 0) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
         it  = raw[$bits(req_item_type)-1:0];
         send_item(it);
      end else begin
         n_push = $urandom_range(4, 0);
         n_eval = $urandom_range(3, 1);
         repeat (n_push) send_item(make_push(pick_point()));
         repeat (n_eval) send_item(make_eval(pick_elapsed()));
         if (sel == 1) wait_results_drained();
      end
   endtask

   task automatic test_random_phases();
      int start_count;
      logic [TIME_BITS-1:0] setting;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       setting = INTERVAL_RESET;
            1:       setting = $urandom_range(TIME_MAX, 1);
            2:       setting = 32'd1;
            3:       setting = $urandom_range(4096, 2);
            4:       setting = TIME_MAX;
            default: setting = 32'h0003_0000;
         endcase
         wait_results_drained();
         write_interval(setting);
         idle_enable = (phase % 3) != 1;
         start_count = items_sent;
         while (items_sent - start_count < 205) run_random_burst();
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < 4; i++) history[i] = '0;
      interval_setting = INTERVAL_RESET;
      idle_enable      = 1'b1;
      hold_request     = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_item         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_history();
      test_segment_extremes();
      test_interval_extremes();
      test_long_hold();
      test_random_phases();
      wait_results_drained();

      $display("Sent %0d items (%0d evaluations, %0d of them late) over %0d interval settings.",
               items_sent, evals_sent, late_expected, settings_used + 1);
      $display("Checked %0d results with %0d mismatches, incl. a %0d-cycle response hold.",
               results_seen, error_count, HOLD_CYCLES);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("tb_catmull_rom_3d_interpolator OK");
      end else begin
         $display("tb_catmull_rom_3d_interpolator NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/cr3d_pkg.sv
src/cr3d_divider.sv
src/cr3d_horner_unit.sv
src/catmull_rom_3d_interpolator.sv
tb/tb_catmull_rom_3d_interpolator.sv
